// File: design/kst_pkg.sv
// Package for the keyed state slot table: request and status codes, the
// controller state type and the layout of one table entry.
// No dependencies; imported by keyed_state_slot_table_core.
package kst_pkg;

  localparam int KEY_W      = 32;
  localparam int VTYPE_W    = 3;
  localparam int BITS_W     = 64;
  localparam int REV_W      = 32;
  localparam int CFG_W      = 7;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 112;

  localparam logic [CFG_W-1:0]   SLOTS_IN_USE_RST = 7'd64;
  localparam logic [REV_W-1:0]   REV_RST          = 32'd1;
  localparam logic [VTYPE_W-1:0] VTYPE_NONE       = 3'd0;
  localparam logic [VTYPE_W-1:0] VTYPE_LAST       = 3'd4;

  typedef enum logic [1:0] {
    ACT_USE   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_SET   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_KEY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic               active;
    logic [KEY_W-1:0]   key;
    logic [VTYPE_W-1:0] vtype;
    logic [BITS_W-1:0]  bits;
    logic [REV_W-1:0]   rev;
    logic               dirty;
  } entry_t;

endpackage

// File: design/keyed_state_slot_table_core.sv
// Keyed slot table: scans a one-port entry memory for a key, then writes back
// at most one entry per request. Depends on kst_pkg.
//
//   channel   | direction | beat contents (lowest bits first)
//   ----------+-----------+----------------------------------------------------
//   s_axis    | in        | tdata: action, key_hash, value_payload; tuser: type
//   m_axis    | out       | tdata: status, slot_index, slot_payload,
//             |           |        slot_revision, slot_dirty, changed;
//             |           | tuser: slot_type
//   cfg       | in        | data: slots_in_use (7 bits)
//
// A request scans the searched region (min(slots_in_use, SLOTS)) with one
// memory read per slot, then decides and writes back; a zero key or an empty
// region skips the scan. A hit ends the scan early. The single memory port
// allows one read or one write per cycle. After reset a clearing pass zeroes
// every entry; no request beat is taken during it. The result sits in an
// output register, so a stalled m_axis holds only the write-back of the next
// request, not its scan.
module keyed_state_slot_table_core #(
  parameter int SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kst_pkg::CFG_W-1:0]           cfg_data,      // slots_in_use
  // requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] action, [33:2] key_hash, [97:34] value_payload, [103:98] zero
  input  logic [kst_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] value_type
  input  logic [kst_pkg::VTYPE_W-1:0]         s_axis_tuser,
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] status, [8:3] slot_index, [72:9] slot_payload,
  // [104:73] slot_revision, [105] slot_dirty, [106] changed, [111:107] zero
  output logic [kst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [2:0] slot_type
  output logic [kst_pkg::VTYPE_W-1:0]         m_axis_tuser
);
  import kst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot address width
  localparam int CW = $clog2(SLOTS + 1);                  // slot count width
  localparam int RW = (CW > CFG_W) ? CW : CFG_W;          // region compare width

  // Configuration register: always ready; the user must write it only while idle, as the block does not enforce this.
  logic [CFG_W-1:0] slots_in_use;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RST;
    end else if (cfg_valid) begin
      slots_in_use <= cfg_data;
    end
  end

  // Region size, saturated to the table depth.
  logic [RW-1:0] cfg_w;
  logic [RW-1:0] slots_w;
  logic [RW-1:0] region_w;
  assign cfg_w    = RW'(slots_in_use);
  assign slots_w  = RW'(SLOTS);
  assign region_w = (cfg_w > slots_w) ? slots_w : cfg_w;

  // Entry memory: one port, read data registered.
  entry_t mem [SLOTS];
  entry_t rd_data;
  logic   [IW-1:0] rd_addr;
  logic            wr_en;
  logic   [IW-1:0] wr_addr;
  entry_t          wr_ent;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    rd_data <= mem[rd_addr];
  end

  // Control and request registers.
  state_t state, state_next;
  logic [CW-1:0]      region;
  logic [CW-1:0]      iss;           // next slot to read
  logic               rd_vld;        // rd_data belongs to rd_idx
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      clr_idx;
  logic               found;
  logic [IW-1:0]      hit_idx;
  entry_t             hit_ent;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [REV_W-1:0]   rev_ctr;
  action_t            req_act;
  logic [KEY_W-1:0]   req_key;
  logic [VTYPE_W-1:0] req_type;
  logic [BITS_W-1:0]  req_bits;

  logic in_beat;
  logic issue;
  logic rd_match;
  logic rd_last;
  logic out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign issue         = (state == S_SCAN) && (iss < region);
  assign rd_addr       = iss[IW-1:0];
  assign rd_match      = rd_vld && rd_data.active && (rd_data.key == req_key);
  assign rd_last       = rd_vld && ((CW'(rd_idx) + CW'(1)) == region);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Result fields chosen in the decide cycle.
  status_t            res_status;
  logic [IW-1:0]      res_idx;
  entry_t             res_ent;
  logic               res_changed;
  logic               rev_inc;
  logic               same_val;
  logic [IW+5:0]      res_idx_ext;

  assign same_val = (hit_ent.vtype == req_type) &&
                    ((req_type == VTYPE_NONE) ||
                     ((req_type <= VTYPE_LAST) && (hit_ent.bits == req_bits)));

  always_comb begin
    state_next  = state;
    wr_en       = 1'b0;
    wr_addr     = clr_idx;
    wr_ent      = '0;
    res_status  = ST_NOT_FOUND;
    res_idx     = hit_idx;
    res_ent     = '0;
    res_changed = 1'b0;
    rev_inc     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (clr_idx == IW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          // bad key or empty region: nothing to scan
          if ((s_axis_tdata[33:2] == '0) || (region_w == '0)) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_match || rd_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (req_key == '0) begin
          res_status = ST_BAD_KEY;
        end else if (found) begin
          res_status = ST_HIT;
          res_ent    = hit_ent;
          wr_addr    = hit_idx;
          case (req_act)
            ACT_CLEAR: begin
              wr_en       = 1'b1;
              wr_ent      = '0;
              res_ent     = '0;
              res_changed = 1'b1;
            end
            ACT_SET: begin
              if (!same_val) begin
                wr_en        = 1'b1;
                wr_ent       = hit_ent;
                wr_ent.vtype = req_type;
                wr_ent.bits  = req_bits;
                wr_ent.rev   = rev_ctr;
                wr_ent.dirty = 1'b1;
                res_ent      = wr_ent;
                res_changed  = 1'b1;
                rev_inc      = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if ((req_act == ACT_FIND) || (req_act == ACT_CLEAR)) begin
          res_status = ST_NOT_FOUND;
        end else if (free_found) begin
          res_status = ST_INSERTED;
          res_idx    = free_idx;
          wr_en      = 1'b1;
          wr_addr    = free_idx;
          wr_ent     = '{active: 1'b1, key: req_key, vtype: req_type,
                         bits: req_bits, rev: rev_ctr, dirty: 1'b0};
          res_ent    = wr_ent;
          rev_inc    = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
        // hold the write-back until the output register can take the result
        if (!out_free) begin
          wr_en   = 1'b0;
          rev_inc = 1'b0;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Scan bookkeeping and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      rev_ctr    <= REV_RST;
      rd_vld     <= 1'b0;
      iss        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IW'(1);
      end
      if (rev_inc) begin
        rev_ctr <= rev_ctr + REV_W'(1);
      end
      rd_vld <= issue;
      if (issue) begin
        iss <= iss + CW'(1);
      end
      if (in_beat) begin
        iss        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else if (state == S_SCAN) begin
        if (rd_match) begin
          found <= 1'b1;
        end
        if (rd_vld && !rd_data.active && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= iss[IW-1:0];
    end
    if (in_beat) begin
      req_act  <= action_t'(s_axis_tdata[1:0]);
      req_key  <= s_axis_tdata[33:2];
      req_bits <= s_axis_tdata[97:34];
      req_type <= s_axis_tuser;
      region   <= CW'(region_w);
    end
    if (state == S_SCAN) begin
      if (rd_match) begin
        hit_idx <= rd_idx;
        hit_ent <= rd_data;
      end
      if (rd_vld && !rd_data.active && !free_found) begin
        free_idx <= rd_idx;
      end
    end
  end

  // Output register: load in the decide cycle, drop on the accepting beat.
  assign res_idx_ext = (IW + 6)'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DECIDE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DECIDE) && out_free) begin
      if ((res_status == ST_HIT) || (res_status == ST_INSERTED)) begin
        m_axis_tuser <= res_ent.vtype;
        m_axis_tdata <= {5'd0, res_changed, res_ent.dirty, res_ent.rev,
                         res_ent.bits, res_idx_ext[5:0], res_status};
      end else begin
        m_axis_tdata <= {5'd0, 1'b0, 1'b0, 32'd0, 64'd0, 6'd0, res_status};
        m_axis_tuser <= '0;
      end
    end
  end

endmodule

// File: dv/tb_keyed_state_slot_table_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_state_slot_table_core: queued request beats, random
// idling on both streams, and a mirror of the slot table that predicts every result.
// Depends on kst_pkg and keyed_state_slot_table_core.
module tb_keyed_state_slot_table_core;
  import kst_pkg::*;

  localparam int SLOTS = 64;
  localparam int IN_PAD = IN_TDATA_W - 2 - KEY_W - BITS_W;
  localparam logic [VTYPE_W-1:0] VTYPE_BOOL = 3'd1;
  localparam int LONG_HOLD = 400;
  // Slowest correct run: ~1700 beats, each with a full scan, the longest sender gap
  // and the longest receiver stall, plus held stretches and the clearing pass, times five.
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    action_t            act;
    logic [KEY_W-1:0]   key;
    logic [VTYPE_W-1:0] vtype;
    logic [BITS_W-1:0]  bits;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         idx;
    logic [VTYPE_W-1:0] vtype;
    logic [BITS_W-1:0]  bits;
    logic [REV_W-1:0]   rev;
    logic               dirty;
    logic               changed;
  } resp_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [VTYPE_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [VTYPE_W-1:0] m_axis_tuser;

  keyed_state_slot_table_core #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Mirror of the slot table and its region register
  logic               mirror_active [SLOTS];
  logic [KEY_W-1:0]   mirror_key    [SLOTS];
  logic [VTYPE_W-1:0] mirror_vtype  [SLOTS];
  logic [BITS_W-1:0]  mirror_bits   [SLOTS];
  logic [REV_W-1:0]   mirror_rev    [SLOTS];
  logic               mirror_dirty  [SLOTS];
  logic [REV_W-1:0]   next_revision = REV_RST;
  logic [CFG_W-1:0]   mirror_region = SLOTS_IN_USE_RST;

  // Key and value pools that make hits, repeats and a full table likely
  logic [KEY_W-1:0]   key_pool   [128];
  logic [VTYPE_W-1:0] vtype_pool [128];
  logic [BITS_W-1:0]  bits_pool  [128];

  req_t  request_backlog [$];
  resp_t awaited_results [$];
  req_t  offer;
  int    queued_cnt = 0;
  int    accepted_cnt = 0;
  int    mismatch_cnt = 0;
  int    setting_cnt = 0;
  int    cycle_cnt = 0;
  int    send_gap = 0;
  int    recv_gap = 0;
  int    hold_left = 0;
  int    long_hold_asks = 0;
  int    long_holds_served = 0;
  int    status_seen [5] = '{0, 0, 0, 0, 0};
  bit    no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one request to the mirror and return the result beat it must produce
  function automatic resp_t table_apply(req_t r);
    resp_t o;
    int    hit;
    int    fr;
    int    n;
    logic  same;
    n = (mirror_region > SLOTS) ? SLOTS : int'(mirror_region);
    hit = -1;
    fr = -1;
    // scan downwards so that the lowest match and the lowest free slot win
    for (int i = n - 1; i >= 0; i--) begin
      if (mirror_active[i] && mirror_key[i] == r.key) hit = i;
      if (!mirror_active[i]) fr = i;
    end
    o = '0;
    if (r.key == '0) begin
      o.status = ST_BAD_KEY;
    end else if (r.act == ACT_FIND) begin
      o.status = (hit < 0) ? ST_NOT_FOUND : ST_HIT;
    end else if (r.act == ACT_CLEAR) begin
      if (hit < 0) begin
        o.status = ST_NOT_FOUND;
      end else begin
        mirror_active[hit] = 1'b0;
        mirror_key[hit] = '0;
        mirror_vtype[hit] = '0;
        mirror_bits[hit] = '0;
        mirror_rev[hit] = '0;
        mirror_dirty[hit] = 1'b0;
        o.status = ST_HIT;
        o.changed = 1'b1;
      end
    end else if (hit >= 0) begin
      o.status = ST_HIT;
      // none equals none whatever the payload; unknown types never compare equal
      same = (mirror_vtype[hit] == r.vtype) &&
             (r.vtype == VTYPE_NONE || (r.vtype <= VTYPE_LAST && mirror_bits[hit] == r.bits));
      if (r.act == ACT_SET && !same) begin
        mirror_vtype[hit] = r.vtype;
        mirror_bits[hit] = r.bits;
        mirror_rev[hit] = next_revision;
        next_revision = next_revision + 1'b1;
        mirror_dirty[hit] = 1'b1;
        o.changed = 1'b1;
      end
    end else if (fr < 0) begin
      o.status = ST_FULL;
    end else begin
      hit = fr;
      mirror_active[fr] = 1'b1;
      mirror_key[fr] = r.key;
      mirror_vtype[fr] = r.vtype;
      mirror_bits[fr] = r.bits;
      mirror_rev[fr] = next_revision;
      next_revision = next_revision + 1'b1;
      mirror_dirty[fr] = 1'b0;
      o.status = ST_INSERTED;
    end
    if (o.status == ST_HIT || o.status == ST_INSERTED) begin
      o.idx = hit[5:0];
      o.vtype = mirror_vtype[hit];
      o.bits = mirror_bits[hit];
      o.rev = mirror_rev[hit];
      o.dirty = mirror_dirty[hit];
    end
    return o;
  endfunction

  function automatic string show(resp_t x);
    return $sformatf("status=%0d slot=%0d type=%0d payload=%h rev=%h dirty=%b changed=%b",
                     x.status, x.idx, x.vtype, x.bits, x.rev, x.dirty, x.changed);
  endfunction

  // Mostly short gaps, a few long ones; none at all in burst stretches
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VTYPE_W-1:0] rand_vtype();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(int'(VTYPE_LAST) + 1, 7));
    return 3'($urandom_range(int'(VTYPE_NONE), int'(VTYPE_LAST)));
  endfunction

  function automatic logic [BITS_W-1:0] rand_payload(input logic [VTYPE_W-1:0] t);
    int r;
    r = $urandom_range(0, 9);
    if (t == VTYPE_BOOL && r < 8) return {63'd0, 1'($urandom_range(0, 1))};
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("result mismatch at cycle %0d: %s", cycle_cnt, what);
  endtask

  task automatic queue_req(input action_t a, input logic [KEY_W-1:0] k,
                           input logic [VTYPE_W-1:0] t, input logic [BITS_W-1:0] b);
    request_backlog.push_back('{act: a, key: k, vtype: t, bits: b});
    queued_cnt++;
  endtask

  task automatic queue_random(input int pool_n);
    int r;
    int p;
    action_t a;
    logic [KEY_W-1:0] k;
    logic [VTYPE_W-1:0] t;
    logic [BITS_W-1:0] b;
    r = $urandom_range(0, 99);
    a = (r < 35) ? ACT_USE : (r < 65) ? ACT_SET : (r < 82) ? ACT_FIND : ACT_CLEAR;
    p = $urandom_range(0, pool_n - 1);
    r = $urandom_range(0, 99);
    if (r < 6) k = '0;
    else if (r < 11) k = $urandom;
    else k = key_pool[p];
    r = $urandom_range(0, 99);
    if (r < 55) begin
      t = vtype_pool[p];
      b = bits_pool[p];
    end else begin
      t = rand_vtype();
      b = rand_payload(t);
      if (r > 85) begin
        vtype_pool[p] = t;
        bits_pool[p] = b;
      end
    end
    queue_req(a, k, t, b);
  endtask

  // Hold until every queued beat is taken and every result has come back
  task automatic wait_drained();
    while (queued_cnt != accepted_cnt || awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_region(input logic [CFG_W-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror_region = v;
    setting_cnt++;
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] region_v, input int pool_n,
                                  input int items, input bit burst, input bit long_hold);
    write_region(region_v);
    no_idle = burst;
    for (int i = 0; i < items / 2; i++) queue_random(pool_n);
    // let the receiver sit on its output while the sender keeps offering
    if (long_hold) long_hold_asks++;
    // pause the sender until everything outstanding has come back
    wait_drained();
    for (int i = items / 2; i < items; i++) queue_random(pool_n);
  endtask

  // Driver: present backlog beats, predict on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(table_apply(offer));
        accepted_cnt++;
        send_gap = gap_len();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          offer = request_backlog.pop_front();
          s_axis_tdata <= {{IN_PAD{1'b0}}, offer.bits, offer.key, offer.act};
          s_axis_tuser <= offer.vtype;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (long_holds_served != long_hold_asks) begin
      long_holds_served++;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) recv_gap = gap_len();
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    resp_t got;
    resp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tdata[2:0]);
      got.idx = m_axis_tdata[8:3];
      got.vtype = m_axis_tuser;
      got.bits = m_axis_tdata[72:9];
      got.rev = m_axis_tdata[104:73];
      got.dirty = m_axis_tdata[105];
      got.changed = m_axis_tdata[106];
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding: %s", show(got)));
      end else begin
        want = awaited_results.pop_front();
        if (int'(want.status) < 5) status_seen[int'(want.status)]++;
        if (got !== want) flag_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    logic [KEY_W-1:0] kc;
    for (int i = 0; i < SLOTS; i++) begin
      mirror_active[i] = 1'b0;
      mirror_key[i] = '0;
      mirror_vtype[i] = '0;
      mirror_bits[i] = '0;
      mirror_rev[i] = '0;
      mirror_dirty[i] = 1'b0;
    end
    for (int i = 0; i < 128; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'h1;
      vtype_pool[i] = rand_vtype();
      bits_pool[i] = rand_payload(vtype_pool[i]);
    end
    ka = 32'hFFFF_FFFF;
    kb = 32'h0000_0001;
    kc = 32'h5A5A_1234;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset region, misses on an empty table, zero key on every action
    queue_req(ACT_FIND, ka, VTYPE_NONE, '0);
    queue_req(ACT_CLEAR, ka, VTYPE_NONE, '0);
    queue_req(ACT_USE, '0, VTYPE_NONE, '0);
    queue_req(ACT_FIND, '0, VTYPE_NONE, '0);
    queue_req(ACT_SET, '0, 3'd7, '1);
    queue_req(ACT_CLEAR, '0, VTYPE_NONE, '0);
    // insert, hit, set with equal and differing values
    queue_req(ACT_USE, ka, 3'd2, '1);
    queue_req(ACT_USE, ka, VTYPE_BOOL, '0);
    queue_req(ACT_SET, ka, 3'd2, '1);
    queue_req(ACT_SET, ka, 3'd3, 64'h8000_0000_0000_0000);
    queue_req(ACT_SET, ka, 3'd3, 64'h8000_0000_0000_0000);
    // set on insert, none against none, unknown types always rewritten
    queue_req(ACT_SET, kb, VTYPE_NONE, '0);
    queue_req(ACT_SET, kb, VTYPE_NONE, '1);
    queue_req(ACT_SET, kb, 3'd7, '0);
    queue_req(ACT_SET, kb, 3'd7, '0);
    queue_req(ACT_SET, kb, VTYPE_LAST, 64'h0000_7FFF_DEAD_BEE0);
    // clear frees the slot, which the next insert takes
    queue_req(ACT_CLEAR, ka, VTYPE_NONE, '0);
    queue_req(ACT_FIND, ka, VTYPE_NONE, '0);
    queue_req(ACT_USE, kc, VTYPE_BOOL, 64'd1);
    queue_req(ACT_FIND, kb, VTYPE_NONE, '0);
    // empty region: use and set report full, find and clear miss
    write_region(7'd0);
    queue_req(ACT_USE, kc, VTYPE_BOOL, 64'd1);
    queue_req(ACT_SET, kc, 3'd2, 64'd5);
    queue_req(ACT_FIND, kc, VTYPE_NONE, '0);
    queue_req(ACT_CLEAR, kb, VTYPE_NONE, '0);
    // one-slot region: a key held beyond it is invisible, the table is full
    write_region(7'd1);
    queue_req(ACT_USE, kb, 3'd2, 64'd9);
    queue_req(ACT_FIND, kc, VTYPE_NONE, '0);

    // Random phases over several region sizes, the extremes among them
    run_random_phase(7'd64, 80, 300, 1'b0, 1'b0);
    run_random_phase(7'd8, 12, 150, 1'b0, 1'b1);
    run_random_phase(7'd3, 5, 120, 1'b1, 1'b0);
    run_random_phase(7'd127, 20, 150, 1'b0, 1'b0);
    run_random_phase(7'd1, 3, 100, 1'b0, 1'b0);
    run_random_phase(7'd16, 24, 150, 1'b0, 1'b1);
    run_random_phase(7'd0, 4, 40, 1'b0, 1'b0);
    run_random_phase(7'd64, 10, 150, 1'b1, 1'b0);
    run_random_phase(7'd5, 8, 150, 1'b0, 1'b0);
    run_random_phase(7'd2, 4, 120, 1'b0, 1'b0);
    run_random_phase(7'd32, 40, 170, 1'b0, 1'b0);

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    $display("Summary: %0d requests over %0d region settings, %0d mismatching results",
             accepted_cnt, setting_cnt, mismatch_cnt);
    $display("Summary: hit %0d, inserted %0d, not found %0d, full %0d, bad key %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
